/* hdl/fsp_pkg.sv */
// ============================================================================
// fsp_pkg - format spec parser shared definitions
// Request/result types, parser state, character codes and the saturating
// decimal digit accumulate.
// ============================================================================
`default_nettype none

package fsp_pkg;

    // Parse phases; codes six and seven are never entered
    typedef enum logic [2:0] {
        PH_FLAGS  = 3'd0,
        PH_WDIG   = 3'd1,
        PH_DOT    = 3'd2,
        PH_PSTART = 3'd3,
        PH_PDIG   = 3'd4,
        PH_LEN    = 3'd5
    } phase_t;

    // Length modifier codes
    localparam logic [3:0] LEN_NONE = 4'd0;
    localparam logic [3:0] LEN_H    = 4'd1;
    localparam logic [3:0] LEN_HH   = 4'd2;
    localparam logic [3:0] LEN_L    = 4'd3;
    localparam logic [3:0] LEN_LL   = 4'd4;
    localparam logic [3:0] LEN_BIGL = 4'd5;
    localparam logic [3:0] LEN_J    = 4'd6;
    localparam logic [3:0] LEN_Z    = 4'd7;
    localparam logic [3:0] LEN_T    = 4'd8;

    // Flag bit masks: left-justify, sign, blank, zero pad, alternate form
    localparam logic [4:0] FLAG_LEFT  = 5'b00001;
    localparam logic [4:0] FLAG_SIGN  = 5'b00010;
    localparam logic [4:0] FLAG_BLANK = 5'b00100;
    localparam logic [4:0] FLAG_PAD   = 5'b01000;
    localparam logic [4:0] FLAG_ALT   = 5'b10000;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_BIGL  = 8'h4C;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_J     = 8'h6A;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_Z     = 8'h7A;

    localparam logic [30:0] SAT_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [7:0]         ch;
        logic signed [31:0] star_value;
    } req_item_t;

    typedef struct packed {
        logic [4:0]         flags;
        logic [30:0]        field_width;
        logic signed [31:0] prec_value;
        logic               prec_given;
        logic [3:0]         length_code;
        logic [7:0]         spec_char;
        logic               error;
    } res_item_t;

    typedef struct packed {
        phase_t      phase;
        logic [4:0]  flag_bits;
        logic [30:0] width_acc;
        logic [31:0] prec_acc;
        logic        prec_seen;
        logic [3:0]  len_acc;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:     PH_FLAGS,
        flag_bits: 5'd0,
        width_acc: 31'd0,
        prec_acc:  32'd0,
        prec_seen: 1'b0,
        len_acc:   LEN_NONE
    };

    // acc * 10 + dig, saturated at SAT_MAX
    function automatic logic [30:0] add_digit(input logic [30:0] acc, input logic [3:0] dig);
        logic [34:0] sum;
        sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, dig};
        if (sum > {4'd0, SAT_MAX})
            return SAT_MAX;
        else
            return sum[30:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/format_spec_parser.sv */
// Timing: a character accepted into the input register is parsed there; its
// result, if any, is written to the result register when the character advances.
// Throughput: one character per cycle, limited only by result back-pressure.
// The parse step (phase cascade plus one x10 digit accumulate) is combinational.
// Reset (rst_n low, async) empties both registers and returns the parser to
// the flags phase with all accumulators cleared.
// ============================================================================
// format_spec_parser - printf conversion specification parser
// Takes the characters after a '%', one per request, and gives one result
// per specifier (or an error result on NUL).
// ============================================================================
`default_nettype none

module format_spec_parser (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    req_valid,
    output logic                   req_stall,
    input  var fsp_pkg::req_item_t req_data,
    output logic                   res_valid,
    input  wire                    res_stall,
    output fsp_pkg::res_item_t     res_data
);

    // input register
    logic               in_valid_reg;
    fsp_pkg::req_item_t in_item_reg;

    // parser state
    fsp_pkg::state_t    state_reg;
    fsp_pkg::state_t    state_next;

    // result register
    logic               res_valid_reg;
    fsp_pkg::res_item_t res_item_reg;

    logic               produce;
    fsp_pkg::res_item_t step_result;
    logic               res_free;
    logic               advance;
    logic               req_accept;

    fsp_step u_step (
        .cur     (state_reg),
        .item    (in_item_reg),
        .nxt     (state_next),
        .produce (produce),
        .result  (step_result)
    );

    // The held character moves on unless it makes a result and the result
    // register is occupied and stalled.
    assign res_free   = !res_valid_reg || !res_stall;
    assign advance    = in_valid_reg && (!produce || res_free);
    assign req_stall  = in_valid_reg && !advance;
    assign req_accept = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req_accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
            in_item_reg <= req_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fsp_pkg::STATE_RESET;
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance && produce)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
            res_item_reg <= step_result;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_item_reg;

    // ---- assertions ----

    // a held character is never dropped or altered
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("held character lost");

    // a result returns the parser to its starting state
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && produce) |=> (state_reg == fsp_pkg::STATE_RESET))
        else $error("state not cleared after result");

    // no precision given means precision value zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_item_reg.prec_given) |-> (res_item_reg.prec_value == 32'sd0))
        else $error("precision value without dot");

    // error flag tracks a NUL specifier
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_item_reg.error == (res_item_reg.spec_char == fsp_pkg::CH_NUL)))
        else $error("error flag mismatch");

    // length code stays within the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_item_reg.length_code <= fsp_pkg::LEN_T))
        else $error("bad length code");

endmodule

`default_nettype wire

/* hdl/fsp_step.sv */
// ============================================================================
// fsp_step - one parse step
// Given the parser state and one character, works out the next state and,
// on a specifier or NUL, the result.
// ============================================================================
`default_nettype none

module fsp_step (
    input  var fsp_pkg::state_t    cur,
    input  var fsp_pkg::req_item_t item,
    output fsp_pkg::state_t        nxt,
    output logic                   produce,
    output fsp_pkg::res_item_t     result
);

    logic [7:0]  c;
    logic [4:0]  flag_mask;
    logic        is_digit;
    logic [3:0]  digit;
    logic [30:0] acc_in;
    logic [30:0] acc_dig;
    logic [31:0] star_mag;
    logic [30:0] star_width;
    logic        star_neg;

    assign c        = item.ch;
    assign is_digit = (c >= fsp_pkg::CH_ZERO) && (c <= fsp_pkg::CH_NINE);
    assign digit    = c[3:0];   // '0'..'9' low nibble is the value
    assign star_neg = item.star_value[31];
    assign star_mag = 32'd0 - item.star_value;
    assign star_width = !star_neg ? item.star_value[30:0]
                      : (star_mag[31] ? fsp_pkg::SAT_MAX : star_mag[30:0]);

    // one shared accumulate: width digits or precision digits
    assign acc_in  = (cur.phase == fsp_pkg::PH_PDIG) ? cur.prec_acc[30:0] : cur.width_acc;
    assign acc_dig = fsp_pkg::add_digit(acc_in, digit);

    always_comb
    begin
        case (c)
            fsp_pkg::CH_MINUS: flag_mask = fsp_pkg::FLAG_LEFT;
            fsp_pkg::CH_PLUS:  flag_mask = fsp_pkg::FLAG_SIGN;
            fsp_pkg::CH_SPACE: flag_mask = fsp_pkg::FLAG_BLANK;
            fsp_pkg::CH_ZERO:  flag_mask = fsp_pkg::FLAG_PAD;
            fsp_pkg::CH_HASH:  flag_mask = fsp_pkg::FLAG_ALT;
            default:           flag_mask = 5'd0;
        endcase
    end

    // next state: phases cascade, an unaccepted char falls to the next one
    always_comb
    begin : next_state
        fsp_pkg::phase_t ph;
        logic            done;
        ph      = cur.phase;
        done    = 1'b0;
        produce = 1'b0;
        nxt     = cur;

        if (ph == fsp_pkg::PH_FLAGS)
        begin
            if (flag_mask != 5'd0)
            begin
                nxt.flag_bits = cur.flag_bits | flag_mask;
                done = 1'b1;
            end
            else if (c == fsp_pkg::CH_STAR)
            begin
                if (star_neg)
                    nxt.flag_bits = cur.flag_bits | fsp_pkg::FLAG_LEFT;
                nxt.width_acc = star_width;
                nxt.phase     = fsp_pkg::PH_DOT;
                done = 1'b1;
            end
            else if (is_digit)
            begin
                nxt.width_acc = {27'd0, digit};
                nxt.phase     = fsp_pkg::PH_WDIG;
                done = 1'b1;
            end
            else
                ph = fsp_pkg::PH_DOT;
        end

        if (!done && ph == fsp_pkg::PH_WDIG)
        begin
            if (is_digit)
            begin
                nxt.width_acc = acc_dig;
                done = 1'b1;
            end
            else
                ph = fsp_pkg::PH_DOT;
        end

        if (!done && ph == fsp_pkg::PH_DOT)
        begin
            if (c == fsp_pkg::CH_DOT)
            begin
                nxt.prec_seen = 1'b1;
                nxt.prec_acc  = 32'd0;
                nxt.phase     = fsp_pkg::PH_PSTART;
                done = 1'b1;
            end
            else
                ph = fsp_pkg::PH_LEN;
        end

        if (!done && ph == fsp_pkg::PH_PSTART)
        begin
            if (c == fsp_pkg::CH_STAR)
            begin
                nxt.prec_acc = item.star_value;
                nxt.phase    = fsp_pkg::PH_LEN;
                done = 1'b1;
            end
            else if (is_digit)
            begin
                nxt.prec_acc = {28'd0, digit};
                nxt.phase    = fsp_pkg::PH_PDIG;
                done = 1'b1;
            end
            else
                ph = fsp_pkg::PH_LEN;
        end

        if (!done && ph == fsp_pkg::PH_PDIG)
        begin
            if (is_digit)
            begin
                nxt.prec_acc = {1'b0, acc_dig};
                done = 1'b1;
            end
        end

        // length modifier, then specifier
        if (!done)
        begin
            nxt.phase = fsp_pkg::PH_LEN;
            done = 1'b1;
            if (cur.len_acc == fsp_pkg::LEN_NONE)
            begin
                case (c)
                    fsp_pkg::CH_H:    nxt.len_acc = fsp_pkg::LEN_H;
                    fsp_pkg::CH_L:    nxt.len_acc = fsp_pkg::LEN_L;
                    fsp_pkg::CH_BIGL: nxt.len_acc = fsp_pkg::LEN_BIGL;
                    fsp_pkg::CH_J:    nxt.len_acc = fsp_pkg::LEN_J;
                    fsp_pkg::CH_Z:    nxt.len_acc = fsp_pkg::LEN_Z;
                    fsp_pkg::CH_T:    nxt.len_acc = fsp_pkg::LEN_T;
                    default:          done = 1'b0;
                endcase
            end
            else if (cur.len_acc == fsp_pkg::LEN_H && c == fsp_pkg::CH_H)
                nxt.len_acc = fsp_pkg::LEN_HH;
            else if (cur.len_acc == fsp_pkg::LEN_L && c == fsp_pkg::CH_L)
                nxt.len_acc = fsp_pkg::LEN_LL;
            else
                done = 1'b0;

            if (!done)
            begin
                produce = 1'b1;
                nxt     = fsp_pkg::STATE_RESET;
            end
        end
    end

    // result fields: nothing is updated on the step that produces
    always_comb
    begin : result_fields
        result.flags       = cur.flag_bits;
        result.field_width = cur.width_acc;
        result.prec_value  = cur.prec_acc;
        result.prec_given  = cur.prec_seen;
        result.length_code = cur.len_acc;
        result.spec_char   = c;
        result.error       = (c == fsp_pkg::CH_NUL);
    end

endmodule

`default_nettype wire

/* sim/tb_format_spec_parser.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_format_spec_parser - format spec parser testbench
// Feeds conversion-spec characters over the request channel and checks every
// result against a cycle-free parser predictor. Directed specs cover the
// flags, star widths and precisions, saturation and every length modifier but z.
// Random specs follow. The request channel idles and the result channel stalls at random.
// ============================================================================

module tb_format_spec_parser;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_CHARS   = 1950;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int MAX_PRINTED    = 40;

    // receiver stall patterns
    localparam int STALL_NONE   = 0;
    localparam int STALL_RANDOM = 1;
    localparam int STALL_TOGGLE = 2;
    localparam int STALL_RUNS   = 3;

    // ------------------------------------------------------------------------
    // Spec scoreboard: parser predictor plus queue of expected specs
    // ------------------------------------------------------------------------
    class spec_scoreboard;
        fsp_pkg::phase_t    ph;
        logic [4:0]         flag_bits;
        logic [30:0]        width_acc;
        logic [31:0]        prec_acc;
        logic               prec_seen;
        logic [3:0]         len_acc;
        fsp_pkg::res_item_t expected_specs[$];
        int                 mismatches;
        int                 checked;
        int                 nul_ends;

        function new();
            clear_parse();
            mismatches = 0;
            checked    = 0;
            nul_ends   = 0;
        endfunction

        function void clear_parse();
            ph        = fsp_pkg::PH_FLAGS;
            flag_bits = 5'd0;
            width_acc = 31'd0;
            prec_acc  = 32'd0;
            prec_seen = 1'b0;
            len_acc   = fsp_pkg::LEN_NONE;
        endfunction

        function int pending();
            return expected_specs.size();
        endfunction

        function logic [4:0] flag_mask(logic [7:0] c);
            case (c)
                fsp_pkg::CH_MINUS: return fsp_pkg::FLAG_LEFT;
                fsp_pkg::CH_PLUS:  return fsp_pkg::FLAG_SIGN;
                fsp_pkg::CH_SPACE: return fsp_pkg::FLAG_BLANK;
                fsp_pkg::CH_ZERO:  return fsp_pkg::FLAG_PAD;
                fsp_pkg::CH_HASH:  return fsp_pkg::FLAG_ALT;
                default:           return 5'd0;
            endcase
        endfunction

        function bit is_dec(logic [7:0] c);
            return (c >= fsp_pkg::CH_ZERO) && (c <= fsp_pkg::CH_NINE);
        endfunction

        // acc*10 + digit, clamped to the 31-bit maximum
        function logic [31:0] push_digit(logic [31:0] acc, logic [7:0] c);
            logic [63:0] v;
            logic [7:0]  d;
            d = c - fsp_pkg::CH_ZERO;
            v = {32'd0, acc} * 64'd10 + {56'd0, d};
            return (v > {33'd0, fsp_pkg::SAT_MAX}) ? {1'b0, fsp_pkg::SAT_MAX} : v[31:0];
        endfunction

        // One accepted request: advance the parse, queue a spec if one ends here
        function void note_request(fsp_pkg::req_item_t r);
            logic [7:0]         c;
            logic [31:0]        sv;
            logic [31:0]        mag;
            logic [4:0]         f;
            logic               taken;
            fsp_pkg::res_item_t e;
            c     = r.ch;
            sv    = r.star_value;
            taken = 1'b0;

            if (ph == fsp_pkg::PH_FLAGS)
            begin
                f = flag_mask(c);
                if (f != 5'd0)
                begin
                    flag_bits = flag_bits | f;
                    taken     = 1'b1;
                end
                else if (c == fsp_pkg::CH_STAR)
                begin
                    // negative star width: left-justify, use the magnitude
                    if (sv[31])
                    begin
                        mag       = -sv;
                        flag_bits = flag_bits | fsp_pkg::FLAG_LEFT;
                        width_acc = mag[31] ? fsp_pkg::SAT_MAX : mag[30:0];
                    end
                    else
                    begin
                        width_acc = sv[30:0];
                    end
                    ph    = fsp_pkg::PH_DOT;
                    taken = 1'b1;
                end
                else if (is_dec(c))
                begin
                    width_acc = 31'(push_digit(32'd0, c));
                    ph        = fsp_pkg::PH_WDIG;
                    taken     = 1'b1;
                end
                else
                begin
                    ph = fsp_pkg::PH_DOT;
                end
            end
            if (!taken && ph == fsp_pkg::PH_WDIG)
            begin
                if (is_dec(c))
                begin
                    width_acc = 31'(push_digit({1'b0, width_acc}, c));
                    taken     = 1'b1;
                end
                else
                begin
                    ph = fsp_pkg::PH_DOT;
                end
            end
            if (!taken && ph == fsp_pkg::PH_DOT)
            begin
                if (c == fsp_pkg::CH_DOT)
                begin
                    prec_seen = 1'b1;
                    prec_acc  = 32'd0;
                    ph        = fsp_pkg::PH_PSTART;
                    taken     = 1'b1;
                end
                else
                begin
                    ph = fsp_pkg::PH_LEN;
                end
            end
            if (!taken && ph == fsp_pkg::PH_PSTART)
            begin
                if (c == fsp_pkg::CH_STAR)
                begin
                    prec_acc = sv;
                    ph       = fsp_pkg::PH_LEN;
                    taken    = 1'b1;
                end
                else if (is_dec(c))
                begin
                    prec_acc = push_digit(32'd0, c);
                    ph       = fsp_pkg::PH_PDIG;
                    taken    = 1'b1;
                end
                else
                begin
                    ph = fsp_pkg::PH_LEN;
                end
            end
            if (!taken && ph == fsp_pkg::PH_PDIG)
            begin
                if (is_dec(c))
                begin
                    prec_acc = push_digit(prec_acc, c);
                    taken    = 1'b1;
                end
                else
                begin
                    ph = fsp_pkg::PH_LEN;
                end
            end
            if (!taken)
            begin
                if (len_acc == fsp_pkg::LEN_NONE)
                begin
                    taken = 1'b1;
                    case (c)
                        fsp_pkg::CH_H:    len_acc = fsp_pkg::LEN_H;
                        fsp_pkg::CH_L:    len_acc = fsp_pkg::LEN_L;
                        fsp_pkg::CH_BIGL: len_acc = fsp_pkg::LEN_BIGL;
                        fsp_pkg::CH_J:    len_acc = fsp_pkg::LEN_J;
                        fsp_pkg::CH_Z:    len_acc = fsp_pkg::LEN_Z;
                        fsp_pkg::CH_T:    len_acc = fsp_pkg::LEN_T;
                        default:          taken = 1'b0;
                    endcase
                end
                else if (len_acc == fsp_pkg::LEN_H && c == fsp_pkg::CH_H)
                begin
                    len_acc = fsp_pkg::LEN_HH;
                    taken   = 1'b1;
                end
                else if (len_acc == fsp_pkg::LEN_L && c == fsp_pkg::CH_L)
                begin
                    len_acc = fsp_pkg::LEN_LL;
                    taken   = 1'b1;
                end
            end
            // anything left is the specifier, NUL included
            if (!taken)
            begin
                e.flags       = flag_bits;
                e.field_width = width_acc;
                e.prec_value  = prec_acc;
                e.prec_given  = prec_seen;
                e.length_code = len_acc;
                e.spec_char   = c;
                e.error       = (c == fsp_pkg::CH_NUL);
                expected_specs.push_back(e);
                clear_parse();
            end
        endfunction

        task report_mismatch(input string msg);
            if (mismatches < MAX_PRINTED)
                $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(input fsp_pkg::res_item_t got);
            fsp_pkg::res_item_t e;
            if (expected_specs.size() == 0)
            begin
                report_mismatch($sformatf("result spec 0x%02h with no spec pending",
                                          got.spec_char));
            end
            else
            begin
                e = expected_specs.pop_front();
                checked++;
                if (got.error)
                    nul_ends++;
                if (got.flags !== e.flags)
                    report_mismatch($sformatf("flags 0x%02h, want 0x%02h", got.flags, e.flags));
                if (got.field_width !== e.field_width)
                    report_mismatch($sformatf("field_width %0d, want %0d",
                                              got.field_width, e.field_width));
                if (got.prec_value !== e.prec_value)
                    report_mismatch($sformatf("prec_value %0d, want %0d",
                                              got.prec_value, e.prec_value));
                if (got.prec_given !== e.prec_given)
                    report_mismatch($sformatf("prec_given %0b, want %0b",
                                              got.prec_given, e.prec_given));
                if (got.length_code !== e.length_code)
                    report_mismatch($sformatf("length_code %0d, want %0d",
                                              got.length_code, e.length_code));
                if (got.spec_char !== e.spec_char)
                    report_mismatch($sformatf("spec_char 0x%02h, want 0x%02h",
                                              got.spec_char, e.spec_char));
                if (got.error !== e.error)
                    report_mismatch($sformatf("error %0b, want %0b", got.error, e.error));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               res_stall = 1'b0;
    fsp_pkg::req_item_t req_data  = '0;
    logic               req_stall;
    logic               res_valid;
    fsp_pkg::res_item_t res_data;

    spec_scoreboard sb = new();

    int sent_chars  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    always #(HALF_PERIOD) clk = ~clk;

    format_spec_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // Monitor: both handshakes sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req_data);
            if (res_valid && !res_stall)
                sb.check_result(res_data);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver back-pressure, with the pattern picked anew at random intervals
    int stall_mode = STALL_NONE;
    int mode_left  = 0;
    int stall_left = 0;

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(STALL_NONE, STALL_RUNS);
            mode_left  <= $urandom_range(20, 80);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            STALL_RANDOM: res_stall <= ($urandom_range(0, 2) == 0);
            STALL_TOGGLE: res_stall <= ~res_stall;
            STALL_RUNS:
            begin
                if (stall_left > 0)
                begin
                    res_stall  <= 1'b1;
                    stall_left <= stall_left - 1;
                end
                else
                begin
                    res_stall <= 1'b0;
                    if ($urandom_range(0, 3) == 0)
                        stall_left <= $urandom_range(1, 12);
                end
            end
            default: res_stall <= 1'b0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    function logic [31:0] pick_star();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'($urandom_range(0, 40)) - 32'd20;
            3:       return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    // Send one request; bursts are separated by random gaps
    task send_req(input logic [7:0] c, input logic [31:0] sv);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_valid           <= 1'b1;
        req_data.ch         <= c;
        req_data.star_value <= sv;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
        sent_chars++;
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_req(s[i], $urandom());
    endtask

    task send_digits(input int n);
        for (int i = 0; i < n; i++)
            send_req(fsp_pkg::CH_ZERO + 8'($urandom_range(0, 9)), $urandom());
    endtask

    // One random spec: mostly well-formed, some noise and cut-off specs
    task send_random_spec();
        string spec_letters;
        int    kind;
        int    n;
        spec_letters = "diouxXfFeEgGaAcspn%";
        if ($urandom_range(0, 99) < 85)
        begin
            n = $urandom_range(0, 4);
            repeat (n)
            begin
                case ($urandom_range(0, 4))
                    0:       send_req(fsp_pkg::CH_MINUS, $urandom());
                    1:       send_req(fsp_pkg::CH_PLUS, $urandom());
                    2:       send_req(fsp_pkg::CH_SPACE, $urandom());
                    3:       send_req(fsp_pkg::CH_ZERO, $urandom());
                    default: send_req(fsp_pkg::CH_HASH, $urandom());
                endcase
            end
            kind = $urandom_range(0, 5);
            case (kind)
                1, 2: send_digits($urandom_range(1, 3));
                3:    send_req(fsp_pkg::CH_STAR, pick_star());
                4:    send_digits($urandom_range(9, 12));
                default: ;
            endcase
            kind = $urandom_range(0, 5);
            if (kind != 0)
                send_req(fsp_pkg::CH_DOT, $urandom());
            case (kind)
                2: send_digits($urandom_range(1, 3));
                3: send_req(fsp_pkg::CH_STAR, pick_star());
                4: send_digits($urandom_range(9, 12));
                default: ;
            endcase
            case ($urandom_range(0, 9))
                1: send_text("h");
                2: send_text("hh");
                3: send_text("l");
                4: send_text("ll");
                5: send_text("L");
                6: send_text("j");
                7: send_text("z");
                8: send_text("t");
                default: ;
            endcase
            if ($urandom_range(0, 9) == 0)
                send_req(8'($urandom_range(0, 255)), $urandom());
            else
                send_req(spec_letters[$urandom_range(0, spec_letters.len() - 1)], $urandom());
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n)
                send_req(8'($urandom_range(0, 255)), pick_star());
            if ($urandom_range(0, 1) == 0)
                send_req(fsp_pkg::CH_NUL, $urandom());
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // all flags, most negative star width, negative star precision, hh
        send_text("-+ 0#");
        send_req(fsp_pkg::CH_STAR, 32'h8000_0000);
        send_req(fsp_pkg::CH_DOT, $urandom());
        send_req(fsp_pkg::CH_STAR, -32'sd7);
        send_text("hhd");
        // star after width digits becomes the specifier
        send_text("12*");
        // largest positive star width, star after precision digits
        send_req(fsp_pkg::CH_STAR, 32'h7FFF_FFFF);
        send_text(".3*");
        // bare dot, then l, ll and a third h
        send_text(".lz");
        send_text("llu");
        send_text("hhh");
        // NUL after gathered fields, and NUL straight away
        send_text("7j");
        send_req(fsp_pkg::CH_NUL, $urandom());
        send_req(fsp_pkg::CH_NUL, $urandom());
        send_text("t");
        send_req(8'hFF, 32'hFFFF_FFFF);
        // width and precision digit saturation
        send_text("2147483648.99999999999Lg");

        while (sent_chars < RANDOM_CHARS)
            send_random_spec();

        // close any open spec, then let the pipe drain
        send_req(fsp_pkg::CH_NUL, $urandom());
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d characters sent, %0d specs checked, %0d of them ended by NUL",
                 sent_chars, sb.checked, sb.nul_ends);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* format_spec_parser.f */
hdl/fsp_pkg.sv
hdl/fsp_step.sv
hdl/format_spec_parser.sv
sim/tb_format_spec_parser.sv
